[src/mrae_pkg.sv]
`timescale 1ns / 1ps

package mrae_pkg;

  // ALU function, opcode bits 5:3
  typedef enum logic [2:0] {
    ALU_ADD = 3'd0,
    ALU_OR  = 3'd1,
    ALU_ADC = 3'd2,
    ALU_SBB = 3'd3,
    ALU_AND = 3'd4,
    ALU_SUB = 3'd5,
    ALU_XOR = 3'd6,
    ALU_CMP = 3'd7
  } alu_fn_t;

  // ModRM mod field codes
  localparam logic [1:0] MOD_NO_DISP = 2'd0;
  localparam logic [1:0] MOD_DISP8   = 2'd1;
  localparam logic [1:0] MOD_DISP16  = 2'd2;
  localparam logic [1:0] MOD_REG     = 2'd3;

  // r/m code that means a direct address when mod is 0
  localparam logic [2:0] RM_DIRECT = 3'd6;

  // opcode bits that must be clear for the group
  localparam logic [7:0] GROUP_MASK = 8'hC4;

  localparam int IN_TDATA_W  = 184;
  localparam int OUT_TDATA_W = 48;

  // first field in the highest bits
  typedef struct packed {
    logic [63:0] regs_sp_bp_si_di;
    logic [63:0] regs_ax_cx_dx_bx;
    logic        carry_in;
    logic [15:0] memory_word;
    logic [15:0] displacement;
    logic [7:0]  modrm_byte;
    logic [7:0]  opcode;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  displacement_bytes;
    logic        word_size;
    logic        write_result;
    logic [2:0]  dest_register;
    logic        dest_is_memory;
    logic        operand_from_memory;
    logic [15:0] effective_address;
    logic [15:0] result;
    logic        is_alu_op;
  } out_item_t;

  localparam int IN_ITEM_W  = $bits(in_item_t);
  localparam int OUT_ITEM_W = $bits(out_item_t);

  // 16-bit register in ModRM numbering: AX CX DX BX SP BP SI DI
  function automatic logic [15:0] reg16(input logic [63:0] lo, input logic [63:0] hi,
                                        input logic [2:0] n);
    logic [63:0] pack;
    pack = n[2] ? hi : lo;
    return pack[16*n[1:0] +: 16];
  endfunction

  // byte size uses AL CL DL BL AH CH DH BH
  function automatic logic [15:0] reg_operand(input logic [63:0] lo, input logic [63:0] hi,
                                              input logic [2:0] n, input logic word);
    logic [15:0] r;
    if (word) begin
      r = reg16(lo, hi, n);
    end else begin
      r = reg16(lo, hi, {1'b0, n[1:0]});
      r = n[2] ? {8'h00, r[15:8]} : {8'h00, r[7:0]};
    end
    return r;
  endfunction

endpackage

[src/modrm_alu_execute_16bit_unit.sv]
`timescale 1ns / 1ps
// ModRM ALU group executor, 16-bit (ADD OR ADC SBB AND SUB XOR CMP).
// Items pass the input register, then the result register; throughput is 1 item per cycle
// unless the output stalls, set by the single decode/ALU pass between the two registers.
// A waiting result holds the result register; the input register still takes one item if empty.
// Reset (rst, synchronous, active high) clears both stage valids; payload is not reset.

module modrm_alu_execute_16bit_unit import mrae_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  // fields low to high: opcode, modrm_byte, displacement, memory_word, carry_in,
  // regs_ax_cx_dx_bx, regs_sp_bp_si_di, zero pad
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
  // fields low to high: is_alu_op, result, effective_address, operand_from_memory,
  // dest_is_memory, dest_register, write_result, word_size, displacement_bytes, zero pad
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  output logic [OUT_TDATA_W-1:0] m_axis_tdata
);

  // stage 1: captured item
  logic      in_valid;
  in_item_t  in_item;
  // stage 2: finished result
  logic      out_valid;
  out_item_t out_item;

  logic        adv_out, adv_in;
  logic [15:0] ea;
  logic [1:0]  ea_bytes;
  out_item_t   res;

  // result register loads when empty or being drained; input register when it can pass on
  assign adv_out = !out_valid || m_axis_tready;
  assign adv_in  = !in_valid || adv_out;

  assign s_axis_tready = adv_in;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (adv_in) begin
      in_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv_in && s_axis_tvalid) begin
      in_item <= in_item_t'(s_axis_tdata[IN_ITEM_W-1:0]);
    end
  end

  // effective address from ModRM and base/index registers
  mrae_ea u_ea (
    .modrm_byte         (in_item.modrm_byte),
    .displacement       (in_item.displacement),
    .regs_ax_cx_dx_bx   (in_item.regs_ax_cx_dx_bx),
    .regs_sp_bp_si_di   (in_item.regs_sp_bp_si_di),
    .effective_address  (ea),
    .displacement_bytes (ea_bytes)
  );

  // operand selection, ALU and output fields
  mrae_exec u_exec (
    .item     (in_item),
    .ea       (ea),
    .ea_bytes (ea_bytes),
    .res      (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv_out) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv_out && in_valid) begin
      out_item <= res;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {{(OUT_TDATA_W-OUT_ITEM_W){1'b0}}, out_item};

endmodule

[src/mrae_ea.sv]
`timescale 1ns / 1ps

module mrae_ea import mrae_pkg::*; (
  input  logic [7:0]  modrm_byte,
  input  logic [15:0] displacement,
  input  logic [63:0] regs_ax_cx_dx_bx,
  input  logic [63:0] regs_sp_bp_si_di,
  output logic [15:0] effective_address,
  output logic [1:0]  displacement_bytes
);

  logic [1:0]  mod_f;
  logic [2:0]  rm;
  logic [15:0] bx, bp, si, di;
  logic [15:0] base;
  logic [15:0] offset;

  assign mod_f = modrm_byte[7:6];
  assign rm    = modrm_byte[2:0];
  assign bx    = regs_ax_cx_dx_bx[63:48];
  assign bp    = regs_sp_bp_si_di[31:16];
  assign si    = regs_sp_bp_si_di[47:32];
  assign di    = regs_sp_bp_si_di[63:48];

  always_comb begin
    unique case (rm)
      3'd0:    base = bx + si;
      3'd1:    base = bx + di;
      3'd2:    base = bp + si;
      3'd3:    base = bp + di;
      3'd4:    base = si;
      3'd5:    base = di;
      3'd6:    base = bp;
      default: base = bx;
    endcase
  end

  always_comb begin
    effective_address  = '0;
    displacement_bytes = 2'd0;
    offset             = '0;
    unique case (mod_f)
      MOD_NO_DISP: begin
        if (rm == RM_DIRECT) begin
          effective_address  = displacement;
          displacement_bytes = 2'd2;
        end else begin
          effective_address = base;
        end
      end
      MOD_DISP8: begin
        offset             = {{8{displacement[7]}}, displacement[7:0]};
        effective_address  = base + offset;
        displacement_bytes = 2'd1;
      end
      MOD_DISP16: begin
        offset             = displacement;
        effective_address  = base + offset;
        displacement_bytes = 2'd2;
      end
      default: begin
        effective_address  = '0;
        displacement_bytes = 2'd0;
      end
    endcase
  end

endmodule

[src/mrae_exec.sv]
`timescale 1ns / 1ps

module mrae_exec import mrae_pkg::*; (
  input  in_item_t    item,
  input  logic [15:0] ea,
  input  logic [1:0]  ea_bytes,
  output out_item_t   res
);

  logic        in_group, word, dir, memop;
  logic [2:0]  rf, rm;
  alu_fn_t     fn;
  logic [15:0] rm_val, reg_val, a, b, r;

  assign in_group = (item.opcode & GROUP_MASK) == 8'h00;
  assign word     = item.opcode[0];
  assign dir      = item.opcode[1];
  assign fn       = alu_fn_t'(item.opcode[5:3]);
  assign rf       = item.modrm_byte[5:3];
  assign rm       = item.modrm_byte[2:0];
  assign memop    = item.modrm_byte[7:6] != MOD_REG;

  always_comb begin
    if (memop) begin
      rm_val = word ? item.memory_word : {8'h00, item.memory_word[7:0]};
    end else begin
      rm_val = reg_operand(item.regs_ax_cx_dx_bx, item.regs_sp_bp_si_di, rm, word);
    end
    reg_val = reg_operand(item.regs_ax_cx_dx_bx, item.regs_sp_bp_si_di, rf, word);
    a = dir ? reg_val : rm_val;
    b = dir ? rm_val : reg_val;
  end

  always_comb begin
    unique case (fn)
      ALU_ADD: r = a + b;
      ALU_OR:  r = a | b;
      ALU_ADC: r = a + b + {15'd0, item.carry_in};
      ALU_SBB: r = a - b - {15'd0, item.carry_in};
      ALU_AND: r = a & b;
      ALU_XOR: r = a ^ b;
      default: r = a - b;  // SUB and CMP
    endcase
  end

  always_comb begin
    res = '0;
    if (in_group) begin
      res.is_alu_op           = 1'b1;
      res.result              = word ? r : {8'h00, r[7:0]};
      res.effective_address   = ea;
      res.operand_from_memory = memop;
      res.dest_is_memory      = !dir && memop;
      res.dest_register       = dir ? rf : (memop ? 3'd0 : rm);
      res.write_result        = fn != ALU_CMP;
      res.word_size           = word;
      res.displacement_bytes  = ea_bytes;
    end
  end

endmodule

[src/mrae_checker.sv]
`timescale 1ns / 1ps

module mrae_checker import mrae_pkg::*; (
  input logic                   clk,
  input logic                   rst,
  input logic                   s_axis_tvalid,
  input logic                   s_axis_tready,
  input logic [IN_TDATA_W-1:0]  s_axis_tdata,
  input logic                   m_axis_tvalid,
  input logic                   m_axis_tready,
  input logic [OUT_TDATA_W-1:0] m_axis_tdata
);

  // an opcode outside the group yields an all-zero item
  a_non_group_zero: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tdata[0] |-> m_axis_tdata[OUT_TDATA_W-1:1] == '0)
    else $error("non-group item carries non-zero fields");

  // displacement count never 3 and pad bits stay zero
  a_disp_bytes: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> m_axis_tdata[41:40] != 2'b11 && m_axis_tdata[OUT_TDATA_W-1:42] == '0)
    else $error("bad displacement byte count or pad");

  // memory destination implies memory operand
  a_dest_mem: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tdata[34] |-> m_axis_tdata[33] && m_axis_tdata[37:35] == 3'd0)
    else $error("memory destination without memory operand");

  // byte-size result fits in 8 bits
  a_byte_mask: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tdata[0] && !m_axis_tdata[39] |-> m_axis_tdata[16:9] == 8'h00)
    else $error("byte result not masked");

  // stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled result changed");

endmodule

bind modrm_alu_execute_16bit_unit mrae_checker u_mrae_checker (.*);
